@@ rtl/periodic_timer_scheduler_assert.svh @@
// Assertion macros for the periodic timer scheduler.
`ifndef PERIODIC_TIMER_SCHEDULER_ASSERT_SVH
`define PERIODIC_TIMER_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("periodic_timer_scheduler: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("periodic_timer_scheduler: assertion failed");

`endif

@@ rtl/ptsch_pkg.sv @@
// Types and constants shared by the periodic timer scheduler modules.
package ptsch_pkg;

	localparam logic [62:0] TIME_MAX = {63{1'b1}};

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CHANGE  = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_PROCESS = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRED  = 2'd1;
	localparam logic [1:0] KIND_NEXT   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_IV    = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic [63:0]        entry_id;
		logic [47:0]        interval_ticks;
		logic               has_base_time;
		logic signed [63:0] base_time;
		logic               miss_policy;
		logic [62:0]        now_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  status;
		logic [63:0] entry_id_out;
		logic [62:0] time_value;
		logic        last;
	} rsp_t;

endpackage

@@ rtl/ptsch_mod.sv @@
// Bit-serial 64 by 48 bit remainder unit, one dividend bit per cycle.
module ptsch_mod import ptsch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [47:0] divisor,
	output logic        done,
	output logic [47:0] rem
);

	logic [63:0] dvd_q;
	logic [47:0] div_q;
	logic [47:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] trial;
	logic [48:0] diff;

	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				dvd_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				rem_q <= diff[48] ? trial[47:0] : diff[47:0];
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ rtl/periodic_timer_scheduler.sv @@
// Periodic timer scheduler: a table of MAX_TIMERS periodic timers driven by one request at
// a time. Every table search walks the slots one per cycle, and base-time alignment runs
// two passes of a shared bit-serial remainder unit. Add or change runs one table search,
// after the alignment when a base time is given; remove and query run one table search;
// clear, unknown operations and a zero interval run none. Process runs a table search per
// timer fired (with a realignment to the old grid where a missed timer asks for it) plus a
// final next-time scan. A result that waits on rsp_stall holds up the sequence. A request
// is taken once the previous one's last result sits in the output register.
module periodic_timer_scheduler import ptsch_pkg::*; #(
	parameter int MAX_TIMERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = $clog2(MAX_TIMERS);
	localparam int NW = $clog2(2 * MAX_TIMERS + 1);
	localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_TIMERS - 1);
	localparam logic [NW-1:0] MAX_FIRES = NW'(2 * MAX_TIMERS);

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_MOD_NOW, S_MOD_BASE, S_ALIGN,
		S_SCAN, S_RESOLVE, S_ADVANCE, S_FIRE, S_EMIT
	} state_t;

	state_t state_q;

	logic [MAX_TIMERS-1:0] slot_valid_q;
	logic [63:0] slot_id_q  [MAX_TIMERS];
	logic [47:0] slot_iv_q  [MAX_TIMERS];
	logic [62:0] slot_due_q [MAX_TIMERS];
	logic        slot_pol_q [MAX_TIMERS];

	logic [63:0] id_ctr_q;
	logic [2:0]  op_q;
	logic [63:0] id_q;
	logic [47:0] iv_q;
	logic        hasb_q;
	logic [63:0] base_q;
	logic        pol_q;
	logic [62:0] now_q;
	logic [62:0] due_q;
	logic [47:0] nowm_q;
	logic [47:0] basem_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic [62:0] best_due_q;
	logic        found_q;
	logic [NW-1:0] fires_q;
	logic [63:0] fire_id_q;
	rsp_t        emit_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic        mod_go_q;
	logic [63:0] mod_dvd_q;
	logic        mod_done;
	logic [47:0] mod_rem;

	logic        hit;
	logic        min_mode;
	logic        fire_now;
	logic [47:0] delay;
	logic [63:0] align_sum;
	logic [63:0] now_iv_sum;
	logic [63:0] due_iv_sum;
	logic [63:0] base_abs;
	logic [62:0] next_time;

	ptsch_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_go_q),
		.dividend (mod_dvd_q),
		.divisor  (iv_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign min_mode = (op_q == OP_PROCESS) || (op_q == OP_QUERY);

	always_comb begin
		unique case (op_q)
			OP_ADD:              hit = !slot_valid_q[idx_q];
			OP_CHANGE, OP_REMOVE: hit = slot_valid_q[idx_q] && (slot_id_q[idx_q] == id_q);
			default:             hit = slot_valid_q[idx_q]
			                           && (!found_q || (slot_due_q[idx_q] < best_due_q));
		endcase
	end

	assign fire_now   = found_q && (best_due_q <= now_q) && (fires_q < MAX_FIRES);
	assign delay      = (nowm_q >= basem_q) ? (nowm_q - basem_q) : (nowm_q + iv_q - basem_q);
	assign align_sum  = {1'b0, now_q} + {16'd0, iv_q} - {16'd0, delay};
	assign now_iv_sum = {1'b0, now_q} + {16'd0, iv_q};
	assign due_iv_sum = {1'b0, best_due_q} + {16'd0, slot_iv_q[best_q]};
	assign base_abs   = base_q[63] ? (64'd0 - base_q) : base_q;
	assign next_time  = found_q ? best_due_q : TIME_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			id_ctr_q     <= '0;
			rsp_valid_q  <= 1'b0;
			mod_go_q     <= 1'b0;
			fires_q      <= '0;
		end else begin
			if (state_q != S_EMIT && rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.operation;
						id_q    <= req.entry_id;
						iv_q    <= req.interval_ticks;
						hasb_q  <= req.has_base_time;
						base_q  <= req.base_time;
						pol_q   <= req.miss_policy;
						now_q   <= req.now_time;
						fires_q <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					emit_q  <= '{KIND_STATUS,
						((op_q == OP_ADD || op_q == OP_CHANGE) && iv_q == '0) ? ST_BAD_IV : ST_OK,
						64'd0, 63'd0, 1'b1};
					idx_q   <= '0;
					found_q <= 1'b0;
					mod_go_q <= (op_q == OP_ADD || op_q == OP_CHANGE) && (iv_q != '0) && hasb_q;
					unique case (op_q)
						OP_ADD, OP_CHANGE: begin
							if (iv_q == '0) begin
								state_q <= S_EMIT;
							end else if (hasb_q) begin
								mod_dvd_q <= {1'b0, now_q};
								state_q   <= S_MOD_NOW;
							end else begin
								due_q   <= now_iv_sum[63] ? TIME_MAX : now_iv_sum[62:0];
								state_q <= S_SCAN;
							end
						end
						OP_REMOVE, OP_PROCESS, OP_QUERY: state_q <= S_SCAN;
						OP_CLEAR: begin
							slot_valid_q <= '0;
							state_q      <= S_EMIT;
						end
						default: state_q <= S_EMIT;
					endcase
				end
				S_MOD_NOW: begin
					mod_go_q <= mod_done;
					if (mod_done) begin
						nowm_q    <= mod_rem;
						mod_dvd_q <= base_abs;
						state_q   <= S_MOD_BASE;
					end
				end
				S_MOD_BASE: begin
					mod_go_q <= 1'b0;
					if (mod_done) begin
						// negative base: fold the remainder of its magnitude forward
						if (base_q[63])
							basem_q <= (mod_rem != '0) ? (iv_q - mod_rem) : '0;
						else
							basem_q <= mod_rem;
						state_q <= S_ALIGN;
					end
				end
				S_ALIGN: begin
					due_q   <= align_sum[63] ? TIME_MAX : align_sum[62:0];
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= (op_q == OP_PROCESS) ? S_FIRE : S_SCAN;
				end
				S_SCAN: begin
					if (hit && (min_mode || !found_q)) begin
						found_q    <= 1'b1;
						best_q     <= idx_q;
						best_due_q <= slot_due_q[idx_q];
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX)
						state_q <= S_RESOLVE;
				end
				S_RESOLVE: begin
					state_q <= (op_q == OP_PROCESS && fire_now) ? S_ADVANCE : S_EMIT;
					unique case (op_q)
						OP_ADD: begin
							if (!found_q) begin
								emit_q.status <= ST_FULL;
							end else begin
								id_ctr_q             <= id_ctr_q + 64'd1;
								slot_valid_q[best_q] <= 1'b1;
								slot_id_q[best_q]    <= id_ctr_q + 64'd1;
								slot_iv_q[best_q]    <= iv_q;
								slot_due_q[best_q]   <= due_q;
								slot_pol_q[best_q]   <= pol_q;
								emit_q.entry_id_out  <= id_ctr_q + 64'd1;
							end
						end
						OP_CHANGE: begin
							if (!found_q) begin
								emit_q.status <= ST_NOT_FOUND;
							end else begin
								slot_iv_q[best_q]  <= iv_q;
								slot_due_q[best_q] <= due_q;
								slot_pol_q[best_q] <= pol_q;
							end
						end
						OP_REMOVE: begin
							if (!found_q)
								emit_q.status <= ST_NOT_FOUND;
							else
								slot_valid_q[best_q] <= 1'b0;
						end
						OP_QUERY: begin
							emit_q <= '{KIND_NEXT, ST_OK, 64'd0, next_time, 1'b1};
						end
						default: begin
							if (fire_now) begin
								due_q     <= due_iv_sum[63] ? TIME_MAX : due_iv_sum[62:0];
								iv_q      <= slot_iv_q[best_q];
								pol_q     <= slot_pol_q[best_q];
								fire_id_q <= slot_id_q[best_q];
							end else begin
								emit_q <= '{KIND_NEXT, ST_OK, 64'd0,
									(next_time < now_q) ? now_q : next_time, 1'b1};
							end
						end
					endcase
				end
				S_ADVANCE: begin
					mod_go_q <= (due_q < now_q) && pol_q;
					// missed cycle: realign to the old grid or restart from now
					if (due_q < now_q) begin
						if (pol_q) begin
							base_q    <= {1'b0, due_q};
							mod_dvd_q <= {1'b0, now_q};
							state_q   <= S_MOD_NOW;
						end else begin
							due_q   <= now_iv_sum[63] ? TIME_MAX : now_iv_sum[62:0];
							state_q <= S_FIRE;
						end
					end else begin
						state_q <= S_FIRE;
					end
				end
				S_FIRE: begin
					slot_due_q[best_q] <= due_q;
					fires_q            <= fires_q + 1'b1;
					emit_q             <= '{KIND_FIRED, ST_OK, fire_id_q, 63'd0, 1'b0};
					state_q            <= S_EMIT;
				end
				S_EMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= emit_q;
						rsp_valid_q <= 1'b1;
						idx_q       <= '0;
						found_q     <= 1'b0;
						state_q     <= emit_q.last ? S_IDLE : S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "periodic_timer_scheduler_assert.svh"

	`PTS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
	`PTS_ASSERT_NOW(a_mod_done_waited, mod_done, state_q == S_MOD_NOW || state_q == S_MOD_BASE)
	`PTS_ASSERT_NOW(a_fire_bound, 1'b1, fires_q <= MAX_FIRES)
	`PTS_ASSERT_NEXT(a_more_after_fired, rsp_valid && !rsp_stall && !rsp.last, req_stall)

endmodule

@@ tb/periodic_timer_scheduler_tb.sv @@
// Testbench for the periodic timer scheduler: directed table, random requests, checked by a predictor.
module periodic_timer_scheduler_tb import ptsch_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int NRAND = 446;
	localparam logic [63:0] TMAX64 = {1'b0, TIME_MAX};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	periodic_timer_scheduler #(.MAX_TIMERS(NSLOT)) i_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// scheduler copy
	logic        tm_valid [NSLOT];
	logic [63:0] tm_id [NSLOT];
	logic [47:0] tm_iv [NSLOT];
	logic [63:0] tm_due [NSLOT];
	logic        tm_pol [NSLOT];
	logic [63:0] id_ctr;

	rsp_t pending_rsp[$];
	int   n_err = 0;
	int   n_rsp = 0;
	int   n_fired = 0;
	int   n_req = 0;
	bit   stim_done = 1'b0;
	bit   hold_long = 1'b0;

	function automatic logic [63:0] sat63(logic [64:0] v);
		return (v > {2'b0, TIME_MAX}) ? TMAX64 : v[63:0];
	endfunction

	function automatic logic [63:0] grid_due(logic [63:0] now, logic [63:0] base,
			logic [47:0] iv);
		logic [63:0] nowm, basem, r, ivx;
		logic [64:0] dly;
		ivx = {16'b0, iv};
		nowm = now % ivx;
		if (!base[63]) basem = base % ivx;
		else begin
			r = (64'd0 - base) % ivx;
			basem = (r != 0) ? ivx - r : 64'd0;
		end
		dly = ({1'b0, nowm} + {1'b0, ivx} - {1'b0, basem}) % {1'b0, ivx};
		return sat63({1'b0, now} + {1'b0, ivx} - dly);
	endfunction

	function automatic int earliest_slot();
		int b;
		b = -1;
		for (int i = 0; i < NSLOT; i++)
			if (tm_valid[i] && (b < 0 || tm_due[i] < tm_due[b])) b = i;
		return b;
	endfunction

	function automatic int slot_of(logic [63:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (tm_valid[i] && tm_id[i] == id) return i;
		return -1;
	endfunction

	function automatic int free_slots();
		int c;
		c = 0;
		for (int i = 0; i < NSLOT; i++) if (!tm_valid[i]) c++;
		return c;
	endfunction

	function automatic rsp_t mk(logic [1:0] k, logic [1:0] st, logic [63:0] id,
			logic [62:0] tv, logic l);
		rsp_t r;
		r.result_kind = k; r.status = st; r.entry_id_out = id; r.time_value = tv; r.last = l;
		return r;
	endfunction

	task automatic predict_schedule(req_t q);
		logic [63:0] now, due;
		int s, n;
		now = {1'b0, q.now_time};
		case (q.operation)
			OP_ADD, OP_CHANGE: begin
				if (q.interval_ticks == 0) begin
					pending_rsp.push_back(mk(KIND_STATUS, ST_BAD_IV, 0, 0, 1)); return;
				end
				due = q.has_base_time ? grid_due(now, q.base_time, q.interval_ticks)
					: sat63({1'b0, now} + q.interval_ticks);
				if (q.operation == OP_ADD) begin
					s = -1;
					for (int i = NSLOT - 1; i >= 0; i--) if (!tm_valid[i]) s = i;
					if (s < 0) begin
						pending_rsp.push_back(mk(KIND_STATUS, ST_FULL, 0, 0, 1)); return;
					end
					id_ctr++;
					tm_valid[s] = 1'b1; tm_id[s] = id_ctr;
					pending_rsp.push_back(mk(KIND_STATUS, ST_OK, id_ctr, 0, 1));
				end else begin
					s = slot_of(q.entry_id);
					if (s < 0) begin
						pending_rsp.push_back(mk(KIND_STATUS, ST_NOT_FOUND, 0, 0, 1)); return;
					end
					pending_rsp.push_back(mk(KIND_STATUS, ST_OK, 0, 0, 1));
				end
				tm_iv[s] = q.interval_ticks; tm_due[s] = due; tm_pol[s] = q.miss_policy;
			end
			OP_REMOVE: begin
				s = slot_of(q.entry_id);
				if (s < 0) pending_rsp.push_back(mk(KIND_STATUS, ST_NOT_FOUND, 0, 0, 1));
				else begin
					tm_valid[s] = 1'b0;
					pending_rsp.push_back(mk(KIND_STATUS, ST_OK, 0, 0, 1));
				end
			end
			OP_PROCESS: begin
				n = 0;
				while (n < 2 * NSLOT) begin
					s = earliest_slot();
					if (s < 0 || tm_due[s] > now) break;
					due = sat63({1'b0, tm_due[s]} + tm_iv[s]);
					if (due < now)
						due = tm_pol[s] ? grid_due(now, due, tm_iv[s])
							: sat63({1'b0, now} + tm_iv[s]);
					tm_due[s] = due;
					pending_rsp.push_back(mk(KIND_FIRED, ST_OK, tm_id[s], 0, 0));
					n++;
				end
				s = earliest_slot();
				due = (s >= 0) ? tm_due[s] : TMAX64;
				if (due < now) due = now;
				pending_rsp.push_back(mk(KIND_NEXT, ST_OK, 0, due[62:0], 1));
			end
			OP_QUERY: begin
				s = earliest_slot();
				due = (s >= 0) ? tm_due[s] : TMAX64;
				pending_rsp.push_back(mk(KIND_NEXT, ST_OK, 0, due[62:0], 1));
			end
			default: begin
				if (q.operation == OP_CLEAR)
					for (int i = 0; i < NSLOT; i++) tm_valid[i] = 1'b0;
				pending_rsp.push_back(mk(KIND_STATUS, ST_OK, 0, 0, 1));
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		n_err++;
	endtask

	// a row with chk set also carries a hand-typed expected first result
	typedef struct {
		logic [2:0]  op;
		logic [63:0] id;
		logic [47:0] iv;
		logic        hb;
		logic [63:0] base;
		logic        pol;
		logic [62:0] now;
		bit          chk;
		rsp_t        want;
	} row_t;
	row_t dir_rows[$];
	rsp_t typed_rsp[$];
	int   typed_at[$];

	function automatic row_t row(logic [2:0] op, logic [63:0] id, logic [47:0] iv,
			logic hb, logic [63:0] base, logic pol, logic [62:0] now);
		row_t r;
		r.op = op; r.id = id; r.iv = iv; r.hb = hb; r.base = base; r.pol = pol;
		r.now = now; r.chk = 1'b0; r.want = '0;
		return r;
	endfunction

	function automatic row_t rowc(row_t r, rsp_t w);
		r.chk = 1'b1; r.want = w;
		return r;
	endfunction

	// request sampled at posedge, next driven at negedge
	task automatic send_req(req_t q, bit chk, rsp_t w);
		req <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		// index of this request's first response among all responses
		if (chk) begin
			typed_at.push_back(n_rsp + pending_rsp.size());
			typed_rsp.push_back(w);
		end
		predict_schedule(q);
		n_req++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic req_t rand_req();
		req_t q;
		int k;
		q.operation = 3'($urandom_range(0, 9));
		if (q.operation > OP_CLEAR) q.operation = (q.operation == 3'd6) ? 3'd7 : OP_PROCESS;
		if ($urandom_range(0, 9) == 0) q.operation = 3'($urandom_range(6, 7));
		k = $urandom_range(0, 4);
		q.entry_id = (k < 3 && id_ctr != 0) ? id_ctr - 64'($urandom_range(0, 20))
			: {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: q.interval_ticks = 48'd0;
			1: q.interval_ticks = 48'({$urandom, $urandom});
			2: q.interval_ticks = 48'hFFFF_FFFF_FFFF;
			default: q.interval_ticks = 48'($urandom_range(1, 300));
		endcase
		q.has_base_time = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: q.base_time = {$urandom, $urandom};
			1: q.base_time = -64'sd1 * $urandom_range(0, 5000);
			default: q.base_time = 64'($urandom_range(0, 20000));
		endcase
		q.miss_policy = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: q.now_time = 63'({$urandom, $urandom});
			1: q.now_time = TIME_MAX - 63'($urandom_range(0, 500));
			default: q.now_time = 63'($urandom_range(0, 20000));
		endcase
		return q;
	endfunction

	task automatic wait_drained();
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// stimulus
	initial begin
		req_t q;
		for (int i = 0; i < NSLOT; i++) tm_valid[i] = 1'b0;
		id_ctr = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		dir_rows.push_back(rowc(row(OP_QUERY, 0, 1, 0, 0, 0, 0),
			mk(KIND_NEXT, ST_OK, 0, TIME_MAX, 1)));
		dir_rows.push_back(rowc(row(OP_ADD, 0, 0, 0, 0, 0, 5),
			mk(KIND_STATUS, ST_BAD_IV, 0, 0, 1)));
		dir_rows.push_back(rowc(row(OP_REMOVE, 64'd77, 1, 0, 0, 0, 0),
			mk(KIND_STATUS, ST_NOT_FOUND, 0, 0, 1)));
		dir_rows.push_back(rowc(row(OP_CHANGE, 64'hFFFF_FFFF_FFFF_FFFF, 5, 0, 0, 0, 0),
			mk(KIND_STATUS, ST_NOT_FOUND, 0, 0, 1)));
		dir_rows.push_back(rowc(row(OP_ADD, 0, 10, 0, 0, 0, 100),
			mk(KIND_STATUS, ST_OK, 64'd1, 0, 1)));
		dir_rows.push_back(row(OP_ADD, 0, 7, 1, 64'd1000, 1, 100));
		dir_rows.push_back(row(OP_ADD, 0, 13, 1, -64'sd3, 0, 100));
		dir_rows.push_back(row(OP_ADD, 0, 48'hFFFF_FFFF_FFFF, 1,
			64'h8000_0000_0000_0000, 1, TIME_MAX));
		dir_rows.push_back(row(OP_ADD, 0, 48'hFFFF_FFFF_FFFF, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0,
			TIME_MAX - 2));
		dir_rows.push_back(row(OP_CHANGE, 64'd1, 4, 1, 64'd3, 0, 120));
		dir_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(OP_PROCESS, 0, 0, 0, 0, 0, 500));
		dir_rows.push_back(row(OP_PROCESS, 0, 0, 0, 0, 0, TIME_MAX));
		dir_rows.push_back(row(OP_REMOVE, 64'd2, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(3'd6, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1,
			64'hFFFF_FFFF_FFFF_FFFF, 1, TIME_MAX));
		dir_rows.push_back(rowc(row(OP_CLEAR, 0, 0, 0, 0, 0, 0),
			mk(KIND_STATUS, ST_OK, 0, 0, 1)));
		foreach (dir_rows[i]) begin
			q.operation = dir_rows[i].op; q.entry_id = dir_rows[i].id;
			q.interval_ticks = dir_rows[i].iv; q.has_base_time = dir_rows[i].hb;
			q.base_time = dir_rows[i].base; q.miss_policy = dir_rows[i].pol;
			q.now_time = dir_rows[i].now;
			send_req(q, dir_rows[i].chk, dir_rows[i].want);
		end
		// fill the table, then one add too many
		for (int i = 0; i <= NSLOT; i++) begin
			q = '0; q.operation = OP_ADD; q.interval_ticks = 48'(i + 1);
			q.now_time = 63'd50;
			send_req(q, 1'b0, '0);
		end
		req_valid <= 1'b0;
		wait_drained();

		// receiver holds off while requests keep coming
		hold_long = 1'b1;
		for (int i = 0; i < NRAND; i++) begin
			q = rand_req();
			if (i == 30) hold_long = 1'b0;
			send_req(q, 1'b0, '0);
			idle_gap();
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver stall pattern
	initial begin
		int ph;
		ph = 0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				rsp_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_long = 1'b0;
			end
			ph++;
			if ((ph / 64) % 3 == 2) rsp_stall <= 1'b0;
			else rsp_stall <= ($urandom_range(0, 99) < 35);
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t w;
		rsp_t t;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (typed_at.size() != 0 && typed_at[0] == n_rsp) begin
				void'(typed_at.pop_front());
				t = typed_rsp.pop_front();
				if (rsp !== t) report_mismatch("typed row", rsp.entry_id_out, t.entry_id_out);
			end
			n_rsp++;
			if (rsp.result_kind == KIND_FIRED) n_fired++;
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp.entry_id_out, 64'd0);
			end else begin
				w = pending_rsp.pop_front();
				if (rsp.result_kind !== w.result_kind)
					report_mismatch("result_kind", 64'(rsp.result_kind), 64'(w.result_kind));
				if (rsp.status !== w.status)
					report_mismatch("status", 64'(rsp.status), 64'(w.status));
				if (rsp.entry_id_out !== w.entry_id_out)
					report_mismatch("entry_id_out", rsp.entry_id_out, w.entry_id_out);
				if (rsp.time_value !== w.time_value)
					report_mismatch("time_value", 64'(rsp.time_value), 64'(w.time_value));
				if (rsp.last !== w.last)
					report_mismatch("last", 64'(rsp.last), 64'(w.last));
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		$display("covered %0d requests, %0d responses, %0d timer firings", n_req, n_rsp, n_fired);
		$display("add/change/remove/process/query/clear with stalls, full table and long hold-off");
		if (n_err == 0 && pending_rsp.size() == 0 && typed_rsp.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#200ms;
		$display("tb: failure");
		$finish;
	end

endmodule
